### design/i2crm_pkg.sv
// Shared types and constants of the I2C register read master.
package i2crm_pkg;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned ADDR_W   = 7;
   localparam int unsigned REG_W    = 8;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned RESULT_W = 13;
   localparam int unsigned CSR_IDX_W = 2;

   // Command codes carried on the request channel.
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCCB_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD    = 2'd2;

   localparam logic [ADDR_W-1:0]   DEVICE_ADDRESS_RESET = 7'd82;
   localparam logic [PERIOD_W-1:0] HALF_PERIOD_RESET    = 16'd400;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x.
   localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
   localparam int unsigned DIV10_SHIFT = 19;

   typedef struct packed {
      logic [ADDR_W-1:0]   device_address;
      logic                sccb_mode;
      logic [PERIOD_W-1:0] half_period;
   } cfg_type;

   typedef struct packed {
      logic                scl_low;
      logic                sda_low;
      logic                busy_res;
      logic                done_res;
      logic [RESULT_W-1:0] result_value;
   } line_type;

endpackage

### design/i2crm_sequencer.sv
// Bus step sequencer: holds the transaction state and works out one tick per item.
module i2crm_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [i2crm_pkg::CMD_W-1:0]   cmd,
   input  logic [i2crm_pkg::REG_W-1:0]   reg_addr,
   input  logic                          sda_in,
   input  i2crm_pkg::cfg_type            cfg,
   output i2crm_pkg::line_type           line
);

   typedef enum logic [4:0] {
      S_IDLE, S_ST_A, S_ST_B, S_TX_A, S_TX_B, S_AK_A, S_AK_B, S_AK_C,
      S_SP_A, S_SP_B, S_SP_C, S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_E,
      S_NK_A, S_NK_B, S_NK_C
   } step_type;

   step_type                              step_ff, step_in;
   logic [i2crm_pkg::PERIOD_W-1:0]        hold_ff, hold_in;
   logic [3:0]                            bit_ff, bit_in;
   logic [7:0]                            shift_ff, shift_in;
   logic [7:0]                            first_ff, first_in;
   logic [i2crm_pkg::CMD_W-1:0]           active_ff, active_in;
   logic [i2crm_pkg::REG_W-1:0]           latched_ff, latched_in;
   logic [i2crm_pkg::RESULT_W-1:0]        result_ff, result_in;
   logic [1:0]                            byte_ff, byte_in;

   logic [i2crm_pkg::PERIOD_W-1:0]        hp;
   logic [7:0]                            tx_byte;
   logic                                  tx_bit;
   logic [31:0]                           product;
   logic                                  scl_l, sda_l, done;

   assign hp      = (cfg.half_period == '0) ? i2crm_pkg::PERIOD_W'(1) : cfg.half_period;
   assign product = {first_ff, shift_ff} * i2crm_pkg::DIV10_MULT;

   always_comb begin
      step_in    = step_ff;
      hold_in    = hold_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      first_in   = first_ff;
      active_in  = active_ff;
      latched_in = latched_ff;
      result_in  = result_ff;
      byte_in    = byte_ff;
      scl_l      = 1'b0;
      sda_l      = 1'b0;
      done       = 1'b0;
      tx_byte    = 8'h00;
      tx_bit     = 1'b0;

      // A command starts a transaction only from idle.
      if (step_ff == S_IDLE && (cmd == i2crm_pkg::CMD_READ || cmd == i2crm_pkg::CMD_MEASURE))
      begin
         active_in  = cmd;
         latched_in = (cmd == i2crm_pkg::CMD_READ) ? reg_addr : '0;
         byte_in    = 2'd0;
         bit_in     = 4'd0;
         shift_in   = 8'h00;
         hold_in    = '0;
         step_in    = S_ST_A;
      end

      if (step_in != S_IDLE) begin
         case (byte_in)
            2'd0:    tx_byte = {cfg.device_address, 1'b0};
            2'd1:    tx_byte = latched_in;
            default: tx_byte = {cfg.device_address, 1'b1};
         endcase
         tx_bit = tx_byte[~bit_in[2:0]];

         case (step_in)
            S_ST_A: begin scl_l = 1'b0; sda_l = 1'b0;       end
            S_ST_B: begin scl_l = 1'b0; sda_l = 1'b1;       end
            S_TX_A: begin scl_l = 1'b1; sda_l = ~tx_bit;    end
            S_TX_B: begin scl_l = 1'b0; sda_l = ~tx_bit;    end
            S_AK_A: begin scl_l = 1'b1; sda_l = 1'b0;       end
            S_AK_B: begin scl_l = 1'b0; sda_l = 1'b0;       end
            S_AK_C: begin scl_l = 1'b1; sda_l = ~tx_byte[0]; end
            S_SP_A: begin scl_l = 1'b1; sda_l = 1'b1;       end
            S_SP_B: begin scl_l = 1'b0; sda_l = 1'b1;       end
            S_RD_B: begin scl_l = (bit_in == 4'd0); sda_l = 1'b0; end
            S_RD_D, S_NK_B, S_SP_C: begin scl_l = 1'b0; sda_l = 1'b0; end
            default: begin scl_l = 1'b1; sda_l = 1'b0;      end
         endcase

         hold_in = hold_in + 1'b1;
         if (hold_in >= hp || hold_in == '0) begin
            hold_in = '0;
            case (step_in)
               S_ST_A: step_in = S_ST_B;
               S_ST_B: begin bit_in = 4'd0; step_in = S_TX_A; end
               S_TX_A: step_in = S_TX_B;
               S_TX_B: begin
                  bit_in  = bit_in + 1'b1;
                  step_in = (bit_in < 4'd8) ? S_TX_A : S_AK_A;
               end
               S_AK_A: step_in = S_AK_B;
               S_AK_B, S_AK_C: begin
                  // A low acknowledge costs one extra low-clock hold first.
                  if (step_in == S_AK_B && !sda_in) begin
                     step_in = S_AK_C;
                  end else if (byte_in == 2'd0) begin
                     byte_in = 2'd1; bit_in = 4'd0; step_in = S_TX_A;
                  end else if (byte_in == 2'd1) begin
                     if (cfg.sccb_mode && active_in == i2crm_pkg::CMD_READ) begin
                        step_in = S_SP_A;
                     end else begin
                        byte_in = 2'd2; step_in = S_ST_A;
                     end
                  end else begin
                     byte_in = 2'd3; bit_in = 4'd0; step_in = S_RD_A;
                  end
               end
               S_SP_A: step_in = S_SP_B;
               S_SP_B: step_in = S_SP_C;
               S_SP_C: begin
                  if (byte_in == 2'd1) begin
                     byte_in = 2'd2; step_in = S_ST_A;
                  end else if (active_in == i2crm_pkg::CMD_MEASURE && latched_in == '0) begin
                     // First half of a measurement done: fetch the low byte.
                     first_in   = shift_in;
                     latched_in = i2crm_pkg::REG_W'(1);
                     byte_in    = 2'd0;
                     bit_in     = 4'd0;
                     shift_in   = 8'h00;
                     hold_in    = '0;
                     step_in    = S_ST_A;
                  end else begin
                     if (active_in == i2crm_pkg::CMD_MEASURE) begin
                        result_in = product[i2crm_pkg::DIV10_SHIFT +: i2crm_pkg::RESULT_W];
                     end else begin
                        result_in = i2crm_pkg::RESULT_W'(shift_in);
                     end
                     step_in = S_IDLE;
                     done    = 1'b1;
                  end
               end
               S_RD_A: step_in = S_RD_B;
               S_RD_B: step_in = S_RD_C;
               S_RD_C: step_in = S_RD_D;
               S_RD_D: begin
                  shift_in = {shift_in[6:0], sda_in};
                  bit_in   = bit_in + 1'b1;
                  step_in  = (bit_in < 4'd8) ? S_RD_B : S_RD_E;
               end
               S_RD_E: step_in = S_NK_A;
               S_NK_A: step_in = S_NK_B;
               S_NK_B: step_in = S_NK_C;
               S_NK_C: step_in = S_SP_A;
               default: step_in = S_IDLE;
            endcase
         end
         line.busy_res = 1'b1;
      end else begin
         line.busy_res = 1'b0;
      end

      line.scl_low      = scl_l;
      line.sda_low      = sda_l;
      line.done_res     = done;
      line.result_value = result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= S_IDLE;
         hold_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         first_ff   <= '0;
         active_ff  <= '0;
         latched_ff <= '0;
         result_ff  <= '0;
         byte_ff    <= '0;
      end else if (step_en) begin
         step_ff    <= step_in;
         hold_ff    <= hold_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         first_ff   <= first_in;
         active_ff  <= active_in;
         latched_ff <= latched_in;
         result_ff  <= result_in;
         byte_ff    <= byte_in;
      end
   end

endmodule

### design/i2c_register_read_master_unit.sv
// Top level of the I2C register read master: channels, configuration and pipeline registers.
//
// Each request item is one tick of an open-drain I2C master. The item carries the
// command (tick only, register read, or distance measurement), a register address
// and the sampled SDA level. Every request item yields exactly one response item
// with the SCL and SDA pull-down controls, a busy flag, a done flag and the last
// completed result (a byte, or (high*256+low)/10 for a measurement).
// An item is captured in the input register, the sequencer works it out in one pass of
// logic, and the response lands in the output register. Throughput is one item per cycle
// while the receiver does not stall; the rate is set by the one-pass state update of the
// sequencer, which advances exactly once per item.
// The three configuration registers (device address, SCCB mode, half period) are
// written through the csr_ port, one write per cycle, with no read-back.
// Reset (synchronous, active high) empties both registers, puts the sequencer at
// idle with both lines released and restores the configuration defaults.
// When the receiver stalls, the response item holds in the output register while
// one more request item may still enter the input register; after that req_tready
// drops until the response is taken. No item is lost or repeated.
module i2c_register_read_master_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // reg_addr[7:0], sda_in[8], zero fill
   input  logic [i2crm_pkg::CMD_W-1:0]       req_tuser,  // command[1:0]
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // scl_low, sda_low, busy_res,
                                                         // result_value[15:3]
   output logic                              rsp_tuser,  // done_res
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [i2crm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2crm_pkg::PERIOD_W-1:0]    csr_wdata
);

   i2crm_pkg::cfg_type               cfg_ff;
   logic                             in_valid_ff;
   logic [i2crm_pkg::CMD_W-1:0]      in_cmd_ff;
   logic [i2crm_pkg::REG_W-1:0]      in_reg_ff;
   logic                             in_sda_ff;
   logic                             rsp_valid_ff;
   i2crm_pkg::line_type              rsp_line_ff;
   i2crm_pkg::line_type              line_in;
   logic                             out_free;
   logic                             advance;

   // The output register can take a new item when empty or being emptied.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.device_address <= i2crm_pkg::DEVICE_ADDRESS_RESET;
         cfg_ff.sccb_mode      <= 1'b0;
         cfg_ff.half_period    <= i2crm_pkg::HALF_PERIOD_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (csr_we) begin
            unique case (csr_index)
               i2crm_pkg::CSR_DEVICE_ADDRESS:
                  cfg_ff.device_address <= csr_wdata[i2crm_pkg::ADDR_W-1:0];
               i2crm_pkg::CSR_SCCB_MODE:
                  cfg_ff.sccb_mode <= csr_wdata[0];
               i2crm_pkg::CSR_HALF_PERIOD:
                  cfg_ff.half_period <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= req_tuser;
         in_reg_ff <= req_tdata[7:0];
         in_sda_ff <= req_tdata[8];
      end
      if (advance) begin
         rsp_line_ff <= line_in;
      end
   end

   i2crm_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .cmd      (in_cmd_ff),
      .reg_addr (in_reg_ff),
      .sda_in   (in_sda_ff),
      .cfg      (cfg_ff),
      .line     (line_in)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_line_ff.result_value, rsp_line_ff.busy_res,
                        rsp_line_ff.sda_low, rsp_line_ff.scl_low};
   assign rsp_tuser  = rsp_line_ff.done_res;

   // A completed command is always reported on a busy tick.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_line_ff.done_res |-> rsp_line_ff.busy_res)
      else $error("done reported on an idle tick");

   // Both bus lines are released while no transaction runs.
   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_line_ff.busy_res |-> !rsp_line_ff.scl_low && !rsp_line_ff.sda_low)
      else $error("bus line pulled low while idle");

   // A waiting input item stays while the output side is blocked.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("input item dropped during a stall");

   // The sequencer only advances when a response slot is free.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_line_ff))
      else $error("response overwritten during a stall");

endmodule

### test/tb_i2c_register_read_master_unit.sv
// Self-checking testbench for the I2C register read master unit.
`timescale 1ns / 1ps

module tb_i2c_register_read_master_unit;

   // The request channel also carries a fourth command code that the block must ignore.
   localparam logic [i2crm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Bus phases of the master, one per held line state.
   typedef enum logic [4:0] {
      SEQ_IDLE,
      SEQ_START_REL,
      SEQ_START_SDA,
      SEQ_TX_CLK_LOW,
      SEQ_TX_CLK_HIGH,
      SEQ_ACK_CLK_LOW,
      SEQ_ACK_CLK_HIGH,
      SEQ_ACK_EXTRA_LOW,
      SEQ_STOP_BOTH_LOW,
      SEQ_STOP_CLK_HIGH,
      SEQ_STOP_RELEASE,
      SEQ_RD_ENTER,
      SEQ_RD_SETUP,
      SEQ_RD_CLK_LOW,
      SEQ_RD_CLK_HIGH,
      SEQ_RD_DONE_LOW,
      SEQ_NACK_CLK_LOW,
      SEQ_NACK_CLK_HIGH,
      SEQ_NACK_TAIL_LOW
   } bus_phase_type;

   // Tracks the bus master tick by tick and holds the line states it should produce.
   class read_master_scoreboard;
      i2crm_pkg::cfg_type                   settings;
      bus_phase_type                        step;
      logic [i2crm_pkg::PERIOD_W-1:0]       hold_count;
      logic [3:0]                           bit_count;
      logic [1:0]                           byte_slot;
      logic [7:0]                           shift_reg;
      logic [7:0]                           high_byte;
      logic [i2crm_pkg::REG_W-1:0]          target_reg;
      logic [i2crm_pkg::CMD_W-1:0]          running_cmd;
      logic [i2crm_pkg::RESULT_W-1:0]       last_result;
      i2crm_pkg::line_type                  expected_lines[$];
      int                                   failures;

      function new();
         settings.device_address = i2crm_pkg::DEVICE_ADDRESS_RESET;
         settings.sccb_mode = 1'b0;
         settings.half_period = i2crm_pkg::HALF_PERIOD_RESET;
         step = SEQ_IDLE;
         hold_count = '0;
         bit_count = '0;
         byte_slot = '0;
         shift_reg = '0;
         high_byte = '0;
         target_reg = '0;
         running_cmd = i2crm_pkg::CMD_TICK;
         last_result = '0;
         failures = 0;
      endfunction

      function bit in_transaction();
         return step != SEQ_IDLE;
      endfunction

      // Address with write bit, then the register, then address with read bit.
      function logic [7:0] outgoing_byte();
         case (byte_slot)
            2'd0: return {settings.device_address, 1'b0};
            2'd1: return target_reg;
            default: return {settings.device_address, 1'b1};
         endcase
      endfunction

      function logic outgoing_bit();
         logic [7:0] value;
         value = outgoing_byte();
         return value[3'd7 - bit_count[2:0]];
      endfunction

      function void start_read();
         byte_slot = 2'd0;
         bit_count = '0;
         shift_reg = '0;
         hold_count = '0;
         step = SEQ_START_REL;
      endfunction

      function void ack_done();
         if (byte_slot == 2'd0) begin
            byte_slot = 2'd1;
            bit_count = '0;
            step = SEQ_TX_CLK_LOW;
         end else if (byte_slot == 2'd1) begin
            // Only a plain register read takes the SCCB stop; a measurement never does.
            if (settings.sccb_mode && running_cmd == i2crm_pkg::CMD_READ) begin
               step = SEQ_STOP_BOTH_LOW;
            end else begin
               byte_slot = 2'd2;
               step = SEQ_START_REL;
            end
         end else begin
            byte_slot = 2'd3;
            bit_count = '0;
            step = SEQ_RD_ENTER;
         end
      endfunction

      // Advances the master by one tick and queues the line state that tick must show.
      function void note_request(logic [i2crm_pkg::CMD_W-1:0] cmd,
                                 logic [i2crm_pkg::REG_W-1:0] reg_addr, logic sda);
         i2crm_pkg::line_type            exp;
         logic [i2crm_pkg::PERIOD_W-1:0] span;
         logic [15:0]                    word;
         logic [7:0]                     sent;
         span = (settings.half_period == '0) ? i2crm_pkg::PERIOD_W'(1) : settings.half_period;
         exp = '0;
         if (step == SEQ_IDLE) begin
            if (cmd == i2crm_pkg::CMD_READ) begin
               running_cmd = i2crm_pkg::CMD_READ;
               target_reg = reg_addr;
               start_read();
            end else if (cmd == i2crm_pkg::CMD_MEASURE) begin
               running_cmd = i2crm_pkg::CMD_MEASURE;
               target_reg = '0;
               start_read();
            end
         end
         if (step == SEQ_IDLE) begin
            exp.result_value = last_result;
            expected_lines.push_back(exp);
            return;
         end
         case (step)
            SEQ_START_REL: ;
            SEQ_START_SDA: exp.sda_low = 1'b1;
            SEQ_TX_CLK_LOW: begin
               exp.scl_low = 1'b1;
               exp.sda_low = ~outgoing_bit();
            end
            SEQ_TX_CLK_HIGH: exp.sda_low = ~outgoing_bit();
            SEQ_ACK_CLK_LOW: exp.scl_low = 1'b1;
            SEQ_ACK_CLK_HIGH: ;
            SEQ_ACK_EXTRA_LOW: begin
               sent = outgoing_byte();
               exp.scl_low = 1'b1;
               exp.sda_low = ~sent[0];
            end
            SEQ_STOP_BOTH_LOW: begin
               exp.scl_low = 1'b1;
               exp.sda_low = 1'b1;
            end
            SEQ_STOP_CLK_HIGH: exp.sda_low = 1'b1;
            SEQ_RD_SETUP: exp.scl_low = (bit_count == '0);
            SEQ_RD_CLK_HIGH, SEQ_NACK_CLK_HIGH, SEQ_STOP_RELEASE: ;
            default: exp.scl_low = 1'b1;
         endcase
         exp.busy_res = 1'b1;
         hold_count = hold_count + 1'b1;
         if (hold_count >= span || hold_count == '0) begin
            hold_count = '0;
            case (step)
               SEQ_START_REL: step = SEQ_START_SDA;
               SEQ_START_SDA: begin
                  bit_count = '0;
                  step = SEQ_TX_CLK_LOW;
               end
               SEQ_TX_CLK_LOW: step = SEQ_TX_CLK_HIGH;
               SEQ_TX_CLK_HIGH: begin
                  bit_count = bit_count + 1'b1;
                  step = (bit_count < 4'd8) ? SEQ_TX_CLK_LOW : SEQ_ACK_CLK_LOW;
               end
               SEQ_ACK_CLK_LOW: step = SEQ_ACK_CLK_HIGH;
               // An acknowledge from the slave costs one more low-clock hold.
               SEQ_ACK_CLK_HIGH: begin
                  if (sda == 1'b0) step = SEQ_ACK_EXTRA_LOW;
                  else ack_done();
               end
               SEQ_ACK_EXTRA_LOW: ack_done();
               SEQ_STOP_BOTH_LOW: step = SEQ_STOP_CLK_HIGH;
               SEQ_STOP_CLK_HIGH: step = SEQ_STOP_RELEASE;
               SEQ_STOP_RELEASE: begin
                  if (byte_slot == 2'd1) begin
                     byte_slot = 2'd2;
                     step = SEQ_START_REL;
                  end else if (running_cmd == i2crm_pkg::CMD_MEASURE && target_reg == '0) begin
                     high_byte = shift_reg;
                     target_reg = i2crm_pkg::REG_W'(1);
                     start_read();
                  end else begin
                     if (running_cmd == i2crm_pkg::CMD_MEASURE) begin
                        word = {high_byte, shift_reg};
                        last_result = i2crm_pkg::RESULT_W'(word / 16'd10);
                     end else begin
                        last_result = i2crm_pkg::RESULT_W'(shift_reg);
                     end
                     step = SEQ_IDLE;
                     exp.done_res = 1'b1;
                  end
               end
               SEQ_RD_ENTER: step = SEQ_RD_SETUP;
               SEQ_RD_SETUP: step = SEQ_RD_CLK_LOW;
               SEQ_RD_CLK_LOW: step = SEQ_RD_CLK_HIGH;
               SEQ_RD_CLK_HIGH: begin
                  shift_reg = {shift_reg[6:0], sda};
                  bit_count = bit_count + 1'b1;
                  step = (bit_count < 4'd8) ? SEQ_RD_SETUP : SEQ_RD_DONE_LOW;
               end
               SEQ_RD_DONE_LOW: step = SEQ_NACK_CLK_LOW;
               SEQ_NACK_CLK_LOW: step = SEQ_NACK_CLK_HIGH;
               SEQ_NACK_CLK_HIGH: step = SEQ_NACK_TAIL_LOW;
               SEQ_NACK_TAIL_LOW: step = SEQ_STOP_BOTH_LOW;
               default: step = SEQ_IDLE;
            endcase
         end
         exp.result_value = last_result;
         expected_lines.push_back(exp);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [15:0] data, logic done_flag);
         i2crm_pkg::line_type exp;
         if (expected_lines.size() == 0) begin
            $display("%0t ns: response item with none expected, tdata %h", $time, data);
            failures++;
            return;
         end
         exp = expected_lines.pop_front();
         compare_field("scl_low", 16'(exp.scl_low), 16'(data[0]));
         compare_field("sda_low", 16'(exp.sda_low), 16'(data[1]));
         compare_field("busy_res", 16'(exp.busy_res), 16'(data[2]));
         compare_field("result_value", 16'(exp.result_value), 16'(data[15:3]));
         compare_field("done_res", 16'(exp.done_res), 16'(done_flag));
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [15:0]                         req_tdata = '0;
   logic [i2crm_pkg::CMD_W-1:0]         req_tuser = i2crm_pkg::CMD_TICK;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [15:0]                         rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_we = 1'b0;
   logic [i2crm_pkg::CSR_IDX_W-1:0]     csr_index = i2crm_pkg::CSR_DEVICE_ADDRESS;
   logic [i2crm_pkg::PERIOD_W-1:0]      csr_wdata = '0;

   read_master_scoreboard sb;

   // Idle percentages for each side, and a pending request for a long receiver hold-off.
   int req_idle_pct = 30;
   int rsp_stall_pct = 56;
   int hold_off_request = 0;
   int hold_left = 0;
   int sent_items = 0;

   i2c_register_read_master_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // The receiver checks every response item as it is taken, then decides whether it
   // takes the next one. A hold-off request from the stimulus keeps tready low for a
   // counted number of cycles, so the input side backs up behind the full pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Offers one tick of the bus to the block and waits for it to be taken. Idle cycles
   // may come first, each drawn with the sender's idle percentage. The scoreboard learns
   // of the item at the edge that accepts it, so the stimulus always sees the master
   // state that follows this tick.
   task automatic send_item(input logic [i2crm_pkg::CMD_W-1:0] cmd,
                            input logic [i2crm_pkg::REG_W-1:0] reg_addr, input logic sda);
      while (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, sda, reg_addr};
      do @(posedge clock); while (!req_tready);
      sent_items++;
      sb.note_request(cmd, reg_addr, sda);
   endtask

   // Stops offering items until every response item is back, then lets the two pipeline
   // stages settle so that the block is truly idle.
   task automatic wait_for_results(input int limit);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.expected_lines.size() != 0 && waited < limit);
      repeat (3) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles; only called with the block idle.
   task automatic write_settings(input logic [i2crm_pkg::ADDR_W-1:0] addr, input logic sccb,
                                 input logic [i2crm_pkg::PERIOD_W-1:0] span);
      csr_we <= 1'b1;
      csr_index <= i2crm_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata <= i2crm_pkg::PERIOD_W'(addr);
      @(posedge clock);
      csr_index <= i2crm_pkg::CSR_SCCB_MODE;
      csr_wdata <= i2crm_pkg::PERIOD_W'(sccb);
      @(posedge clock);
      csr_index <= i2crm_pkg::CSR_HALF_PERIOD;
      csr_wdata <= span;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.settings.device_address = addr;
      sb.settings.sccb_mode = sccb;
      sb.settings.half_period = span;
   endtask

   // Short bus steps keep each transaction to a few hundred ticks at most.
   task automatic write_random_settings();
      wait_for_results(20000);
      write_settings(i2crm_pkg::ADDR_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                     i2crm_pkg::PERIOD_W'($urandom_range(0, 2)));
   endtask

   // Issues one command and keeps ticking until the master is idle again. The slave
   // drives SDA high with the given percentage, which sets how often acknowledges
   // come and what the read bytes look like. Some ticks carry a stray command that
   // the busy master must ignore.
   task automatic run_transaction(input logic [i2crm_pkg::CMD_W-1:0] cmd,
                                  input logic [i2crm_pkg::REG_W-1:0] reg_addr,
                                  input int high_pct, input int noise_pct);
      logic [i2crm_pkg::CMD_W-1:0] stray;
      send_item(cmd, reg_addr, $urandom_range(0, 99) < high_pct);
      while (sb.in_transaction()) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            case ($urandom_range(0, 2))
               0: stray = i2crm_pkg::CMD_READ;
               1: stray = i2crm_pkg::CMD_MEASURE;
               default: stray = CMD_UNUSED;
            endcase
         end else begin
            stray = i2crm_pkg::CMD_TICK;
         end
         send_item(stray, i2crm_pkg::REG_W'($urandom), $urandom_range(0, 99) < high_pct);
      end
   endtask

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int profile;
      int pick;
      int random_base;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The reset bus step of 400 ticks would make every transaction
      // last tens of thousands of items, so the step is shortened first, to zero,
      // which the block must treat as one.
      write_settings(7'd127, 1'b0, 16'd0);
      // Idle ticks keep both lines released; the unused command code does nothing.
      send_item(i2crm_pkg::CMD_TICK, 8'hFF, 1'b1);
      send_item(CMD_UNUSED, 8'h00, 1'b0);
      send_item(CMD_UNUSED, 8'hFF, 1'b1);
      // A slave that never acknowledges and returns all ones.
      run_transaction(i2crm_pkg::CMD_READ, 8'hFF, 100, 0);
      // Both bytes all ones give the largest distance, which needs all 13 bits.
      run_transaction(i2crm_pkg::CMD_MEASURE, 8'h5A, 100, 0);

      // SCCB mode: a stop before the repeated start, but only for a register read.
      wait_for_results(20000);
      write_settings(7'd0, 1'b1, 16'd1);
      run_transaction(i2crm_pkg::CMD_READ, 8'hA5, 50, 30);
      run_transaction(i2crm_pkg::CMD_MEASURE, 8'h00, 50, 30);

      // The longest bus step only gets idle traffic: a transaction would take millions
      // of ticks.
      wait_for_results(20000);
      write_settings(7'h2A, 1'b0, 16'hFFFF);
      repeat (12) send_item($urandom_range(0, 1) ? i2crm_pkg::CMD_TICK : CMD_UNUSED,
                            i2crm_pkg::REG_W'($urandom), 1'($urandom));

      // Random part in three idling profiles: sender idles less than the receiver, then
      // the reverse, then no idling at all. Most of the traffic is complete transactions
      // with random slave data; the rest is idle noise between them.
      random_base = sent_items;
      for (profile = 0; profile < 3; profile++) begin
         case (profile)
            0: begin
               req_idle_pct = 30;
               rsp_stall_pct = 56;
            end
            1: begin
               req_idle_pct = 56;
               rsp_stall_pct = 30;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         write_random_settings();
         // Long receiver stall while the sender keeps offering items, so the block
         // fills and drops req_tready.
         if (profile == 0) hold_off_request = 64;
         do begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               run_transaction(i2crm_pkg::CMD_READ, i2crm_pkg::REG_W'($urandom),
                               $urandom_range(0, 100), $urandom_range(0, 20));
            end else if (pick < 80) begin
               run_transaction(i2crm_pkg::CMD_MEASURE, i2crm_pkg::REG_W'($urandom),
                               $urandom_range(0, 100), $urandom_range(0, 20));
            end else begin
               repeat ($urandom_range(1, 6))
                  send_item($urandom_range(0, 1) ? i2crm_pkg::CMD_TICK : CMD_UNUSED,
                            i2crm_pkg::REG_W'($urandom), 1'($urandom));
            end
            // Now and then the sender pauses until everything is back and the
            // settings change.
            if ($urandom_range(0, 15) == 0) write_random_settings();
         end while (sent_items < random_base + 140 * (profile + 1));
      end

      wait_for_results(20000);
      repeat (8) @(posedge clock);
      if (sb.expected_lines.size() != 0) begin
         $display("%0t ns: %0d expected response items never arrived", $time,
                  sb.expected_lines.size());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
